// ===== rtl/ccl_pkg.sv =====
`default_nettype none

package ccl_pkg;

    // Input transaction: one header value byte plus framing flags
    typedef struct packed {
        logic [7:0] char_byte;
        logic       byte_valid;
        logic       value_end;
        logic       message_start;
    } ccl_in_t;

    // Result transaction: status and collected codings
    typedef struct packed {
        logic [1:0] parse_status;
        logic [1:0] coding_count;
        logic [1:0] first_coding;
        logic [1:0] second_coding;
    } ccl_out_t;

    // Parse status codes
    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_INVALID     = 2'd1;
    localparam logic [1:0] STATUS_UNSUPPORTED = 2'd2;

    // Coding codes
    localparam logic [1:0] CODING_IDENTITY = 2'd0;
    localparam logic [1:0] CODING_GZIP     = 2'd1;
    localparam logic [1:0] CODING_DEFLATE  = 2'd2;
    localparam logic [1:0] CODING_BROTLI   = 2'd3;

    localparam int          NUM_KEYWORDS = 4;
    localparam logic [1:0]  MAX_CODINGS  = 2'd2;
    localparam logic [3:0]  POS_SAT      = 4'd9;
    localparam logic [3:0]  ALL_ALIVE    = 4'hF;

    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    // Keyword text, left aligned, zero padded
    localparam logic [63:0] KW_IDENTITY = "identity";
    localparam logic [63:0] KW_GZIP     = {"gzip", 32'h0};
    localparam logic [63:0] KW_DEFLATE  = {"deflate", 8'h0};
    localparam logic [63:0] KW_BR       = {"br", 48'h0};

    function automatic logic [3:0] kw_len(input logic [1:0] k);
        logic [3:0] len;
        case (k)
            CODING_IDENTITY: len = 4'd8;
            CODING_GZIP:     len = 4'd4;
            CODING_DEFLATE:  len = 4'd7;
            CODING_BROTLI:   len = 4'd2;
            default:         len = 4'd0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] idx);
        logic [63:0] word;
        case (k)
            CODING_IDENTITY: word = KW_IDENTITY;
            CODING_GZIP:     word = KW_GZIP;
            CODING_DEFLATE:  word = KW_DEFLATE;
            CODING_BROTLI:   word = KW_BR;
            default:         word = 64'h0;
        endcase
        return word[8 * (3'd7 - idx) +: 8];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ccl_parse_core.sv =====
`default_nettype none

module ccl_parse_core (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             item_en,
    input  wire ccl_pkg::ccl_in_t item,
    output logic                  res_push,
    output ccl_pkg::ccl_out_t     res_data
);

    logic [1:0] count_reg, count_next;
    logic [1:0] coding0_reg, coding0_next;
    logic [1:0] coding1_reg, coding1_next;
    logic [1:0] err_reg, err_next;
    logic [3:0] pos_reg, pos_next;
    logic [3:0] alive_reg, alive_next;
    logic       wsac_reg, wsac_next;
    logic       jac_reg, jac_next;

    // Per-transaction state update
    always_comb begin
        logic       do_comma;
        logic       run_end;
        logic       hit;
        logic [1:0] code;
        logic [7:0] low;

        count_next  = count_reg;
        coding0_next = coding0_reg;
        coding1_next = coding1_reg;
        err_next    = err_reg;
        pos_next    = pos_reg;
        alive_next  = alive_reg;
        wsac_next   = wsac_reg;
        jac_next    = jac_reg;
        do_comma    = 1'b0;
        hit         = 1'b0;
        code        = ccl_pkg::CODING_IDENTITY;
        low         = item.char_byte;

        // message start clears everything first
        if (item.message_start) begin
            count_next   = 2'd0;
            coding0_next = ccl_pkg::CODING_IDENTITY;
            coding1_next = ccl_pkg::CODING_IDENTITY;
            err_next     = ccl_pkg::STATUS_OK;
            pos_next     = 4'd0;
            alive_next   = ccl_pkg::ALL_ALIVE;
            wsac_next    = 1'b0;
            jac_next     = 1'b0;
        end

        // byte handling; a comma leaves the token intact for the end check
        if (err_next == ccl_pkg::STATUS_OK && item.byte_valid) begin
            if (item.char_byte == ccl_pkg::CHAR_COMMA) begin
                do_comma = 1'b1;
            end else if (item.char_byte == ccl_pkg::CHAR_SPACE ||
                         item.char_byte == ccl_pkg::CHAR_TAB) begin
                jac_next = 1'b0;
                if (pos_next != 4'd0) begin
                    wsac_next = 1'b1;
                end
            end else begin
                jac_next = 1'b0;
                if (wsac_next) begin
                    alive_next = 4'd0;
                    wsac_next  = 1'b0;
                end
                if (item.char_byte >= ccl_pkg::CHAR_UPPER_A &&
                    item.char_byte <= ccl_pkg::CHAR_UPPER_Z) begin
                    low = item.char_byte + ccl_pkg::CASE_OFFSET;
                end
                for (int k = 0; k < ccl_pkg::NUM_KEYWORDS; k++) begin
                    if (pos_next >= ccl_pkg::kw_len(2'(k)) ||
                        ccl_pkg::kw_char(2'(k), pos_next[2:0]) != low) begin
                        alive_next[k] = 1'b0;
                    end
                end
                if (pos_next < ccl_pkg::POS_SAT) begin
                    pos_next = pos_next + 4'd1;
                end
            end
        end

        // token end: at a comma, or at value end not right after a comma
        run_end = do_comma ||
                  (item.value_end && err_next == ccl_pkg::STATUS_OK && !jac_next);
        if (run_end) begin
            if (count_next >= ccl_pkg::MAX_CODINGS) begin
                err_next = ccl_pkg::STATUS_UNSUPPORTED;
            end else if (pos_next == 4'd0) begin
                err_next = ccl_pkg::STATUS_INVALID;
            end else begin
                for (int k = 0; k < ccl_pkg::NUM_KEYWORDS; k++) begin
                    if (alive_next[k] && pos_next == ccl_pkg::kw_len(2'(k))) begin
                        hit  = 1'b1;
                        code = 2'(k);
                    end
                end
                if (hit) begin
                    if (count_next[0]) begin
                        coding1_next = code;
                    end else begin
                        coding0_next = code;
                    end
                    count_next = count_next + 2'd1;
                end else begin
                    err_next = ccl_pkg::STATUS_UNSUPPORTED;
                end
            end
        end

        if (do_comma) begin
            pos_next   = 4'd0;
            alive_next = ccl_pkg::ALL_ALIVE;
            wsac_next  = 1'b0;
            jac_next   = 1'b1;
        end

        // value end: trailing comma check, then fresh token
        if (item.value_end) begin
            if (err_next == ccl_pkg::STATUS_OK && jac_next) begin
                err_next = ccl_pkg::STATUS_INVALID;
            end
            pos_next   = 4'd0;
            alive_next = ccl_pkg::ALL_ALIVE;
            wsac_next  = 1'b0;
            jac_next   = 1'b0;
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= 2'd0;
            coding0_reg <= ccl_pkg::CODING_IDENTITY;
            coding1_reg <= ccl_pkg::CODING_IDENTITY;
            err_reg     <= ccl_pkg::STATUS_OK;
            pos_reg     <= 4'd0;
            alive_reg   <= ccl_pkg::ALL_ALIVE;
            wsac_reg    <= 1'b0;
            jac_reg     <= 1'b0;
        end else if (item_en) begin
            count_reg   <= count_next;
            coding0_reg <= coding0_next;
            coding1_reg <= coding1_next;
            err_reg     <= err_next;
            pos_reg     <= pos_next;
            alive_reg   <= alive_next;
            wsac_reg    <= wsac_next;
            jac_reg     <= jac_next;
        end
    end

    // Result for a value-end transaction
    always_comb begin
        res_push = item_en && item.value_end;
        res_data.parse_status  = err_next;
        res_data.coding_count  = count_next;
        res_data.first_coding  = (count_next >= 2'd1) ? coding0_next
                                                      : ccl_pkg::CODING_IDENTITY;
        res_data.second_coding = (count_next >= 2'd2) ? coding1_next
                                                      : ccl_pkg::CODING_IDENTITY;
    end

    // Checks
    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= ccl_pkg::MAX_CODINGS)
        else $error("coding count above limit");

    a_err_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (err_reg != ccl_pkg::STATUS_OK && !(item_en && item.message_start))
        |=> err_reg == $past(err_reg))
        else $error("held error changed without message start");

    a_count_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        (err_reg != ccl_pkg::STATUS_OK && !(item_en && item.message_start))
        |=> count_reg == $past(count_reg))
        else $error("codings collected after an error");

    a_pos_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= ccl_pkg::POS_SAT)
        else $error("token position beyond saturation");

endmodule

`default_nettype wire

// ===== rtl/ccl_out_stage.sv =====
`default_nettype none

module ccl_out_stage (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire ccl_pkg::ccl_out_t push_data,
    output logic                   can_accept,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output ccl_pkg::ccl_out_t      m_payload
);

    logic              valid_reg;
    ccl_pkg::ccl_out_t data_reg;

    // Room when empty or when the held result leaves this cycle
    assign can_accept = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (push) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            data_reg <= push_data;
        end
    end

    assign m_valid   = valid_reg;
    assign m_payload = data_reg;

endmodule

`default_nettype wire

// ===== rtl/content_coding_list_parser_unit.sv =====
// Content-Encoding list parser, one header value byte per transaction.
// Throughput: one input transaction per cycle, unless a held result waits on m_ready.
// A value-end transaction's result is registered and shows on m_valid in the cycle after acceptance.
// A result waiting in the output register does not stop input while m_ready is high.
// Reset: aresetn is synchronous, active low; it clears codings, error, token state
// and the output valid flag.
`default_nettype none

module content_coding_list_parser_unit (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire ccl_pkg::ccl_in_t s_payload,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output ccl_pkg::ccl_out_t     m_payload
);

    logic              item_en;
    logic              res_push;
    ccl_pkg::ccl_out_t res_data;

    assign item_en = s_valid && s_ready;

    ccl_parse_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .item_en  (item_en),
        .item     (s_payload),
        .res_push (res_push),
        .res_data (res_data)
    );

    ccl_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (res_push),
        .push_data  (res_data),
        .can_accept (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_payload  (m_payload)
    );

endmodule

`default_nettype wire
